### hdl/dmwbc_pkg.sv
// Shared types and codes for the direct-mapped write-back cache.
`default_nettype none
package dmwbc_pkg;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Beat widths of the output and input streams.
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 24;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_TAG   = 7'b0000100,
    ST_HIT   = 7'b0001000,
    ST_WB    = 7'b0010000,
    ST_FILL  = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

### hdl/dmwbc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
`default_nettype none
module dmwbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/direct_mapped_write_back_cache.sv
// Direct-mapped write-back write-allocate byte cache with its backing memory.
//
// Byte reads and writes enter on the s_ side; each read returns one beat on the
// m_ side with the byte, a hit flag and the dirty mark (of the line on a hit, of
// the evicted line on a miss); writes return nothing. Tags, line bytes and the
// backing memory sit in synchronous RAMs with a registered read, and line
// transfers move one byte per cycle through them. After reset the block runs a
// clearing pass over every backing address that zeroes the backing memory, line
// data and tags, with s_tready low. A miss refills the line byte by byte from the
// backing memory, first writing a dirty line back byte by byte. The block takes
// no new request until the last one is done, but a new request is taken while a
// read result still waits on the m_ side.
`default_nettype none
module direct_mapped_write_back_cache
  import dmwbc_pkg::*;
#(
  parameter int unsigned LINE_COUNT = 32,
  parameter int unsigned LINE_BYTES = 8,
  parameter int unsigned ADDR_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // address[15:0], write_data[23:16]
  input  wire logic                   s_tuser,   // req_type
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata    // read_data[7:0], hit[8], dirty[9]
);

  localparam int unsigned OFF_W   = $clog2(LINE_BYTES);
  localparam int unsigned IDX_W   = $clog2(LINE_COUNT);
  localparam int unsigned TAG_W   = ADDR_BITS - OFF_W - IDX_W;
  localparam int unsigned DATA_AW = IDX_W + OFF_W;
  localparam logic [OFF_W-1:0] LAST_BYTE = OFF_W'(LINE_BYTES - 1);

  state_t state;

  logic [ADDR_BITS-1:0] clr_cnt;
  logic [OFF_W-1:0]     k;
  logic                 req_write;
  logic [TAG_W-1:0]     req_tag;
  logic [IDX_W-1:0]     req_idx;
  logic [OFF_W-1:0]     req_off;
  logic [7:0]           req_wdata;
  logic [TAG_W-1:0]     old_tag;
  logic                 old_dirty;
  logic [7:0]           res_data;
  logic                 res_hit;

  // address masked to the backing memory size
  logic [ADDR_BITS+15:0] addr_wide;
  logic [ADDR_BITS-1:0]  addr_m;
  assign addr_wide = {{ADDR_BITS{1'b0}}, s_tdata[15:0]};
  assign addr_m    = addr_wide[ADDR_BITS-1:0];

  // RAM ports
  logic                 tag_we;
  logic [IDX_W-1:0]     tag_waddr, tag_raddr;
  logic [TAG_W:0]       tag_wdata, tag_rdata;
  logic                 data_we;
  logic [DATA_AW-1:0]   data_waddr, data_raddr;
  logic [7:0]           data_wdata, data_rdata;
  logic                 back_we;
  logic [ADDR_BITS-1:0] back_waddr, back_raddr;
  logic [7:0]           back_wdata, back_rdata;

  logic [TAG_W-1:0] rd_tag;
  logic             rd_dirty;
  logic             is_hit;
  logic [OFF_W-1:0] k_inc;
  logic             out_free;

  assign rd_tag   = tag_rdata[TAG_W-1:0];
  assign rd_dirty = tag_rdata[TAG_W];
  assign is_hit   = (rd_tag == req_tag);
  assign k_inc    = k + OFF_W'(1);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = req_idx;
    tag_wdata  = {1'b0, req_tag};
    tag_raddr  = addr_m[OFF_W +: IDX_W];
    data_we    = 1'b0;
    data_waddr = {req_idx, k};
    data_wdata = back_rdata;
    data_raddr = {req_idx, req_off};
    back_we    = 1'b0;
    back_waddr = {old_tag, req_idx, k};
    back_wdata = data_rdata;
    back_raddr = {req_tag, req_idx, {OFF_W{1'b0}}};
    case (state)
      ST_CLEAR: begin
        tag_we     = 1'b1;
        tag_waddr  = clr_cnt[IDX_W-1:0];
        tag_wdata  = '0;
        data_we    = 1'b1;
        data_waddr = clr_cnt[DATA_AW-1:0];
        data_wdata = 8'h00;
        back_we    = 1'b1;
        back_waddr = clr_cnt;
        back_wdata = 8'h00;
      end
      ST_TAG: begin
        if (is_hit) begin
          if (req_write) begin
            data_we    = 1'b1;
            data_waddr = {req_idx, req_off};
            data_wdata = req_wdata;
            tag_we     = 1'b1;
            tag_wdata  = {1'b1, req_tag};
          end
        end else begin
          // start the write-back read at byte 0
          data_raddr = {req_idx, {OFF_W{1'b0}}};
        end
      end
      ST_WB: begin
        back_we    = 1'b1;
        data_raddr = {req_idx, k_inc};
      end
      ST_FILL: begin
        data_we    = 1'b1;
        data_wdata = (req_write && k == req_off) ? req_wdata : back_rdata;
        back_raddr = {req_tag, req_idx, k_inc};
        if (k == LAST_BYTE) begin
          tag_we    = 1'b1;
          tag_wdata = {req_write, req_tag};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_BITS'(1);
          if (clr_cnt == {ADDR_BITS{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_TAG;
          end
        end
        ST_TAG: begin
          k <= '0;
          if (is_hit) begin
            state <= (req_write == REQ_WRITE) ? ST_IDLE : ST_HIT;
          end else if (rd_dirty) begin
            state <= ST_WB;
          end else begin
            state <= ST_FILL;
          end
        end
        ST_HIT: begin
          state <= ST_RESP;
        end
        ST_WB: begin
          k <= k_inc;
          if (k == LAST_BYTE) begin
            state <= ST_FILL;
          end
        end
        ST_FILL: begin
          k <= k_inc;
          if (k == LAST_BYTE) begin
            state <= (req_write == REQ_WRITE) ? ST_IDLE : ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        req_write <= s_tuser;
        req_tag   <= addr_m[ADDR_BITS-1 -: TAG_W];
        req_idx   <= addr_m[OFF_W +: IDX_W];
        req_off   <= addr_m[OFF_W-1:0];
        req_wdata <= s_tdata[23:16];
      end
      ST_TAG: begin
        old_tag   <= rd_tag;
        old_dirty <= rd_dirty;
        res_hit   <= is_hit;
      end
      ST_HIT: begin
        res_data <= data_rdata;
      end
      ST_FILL: begin
        if (k == req_off) begin
          res_data <= back_rdata;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          m_tdata <= {{(OUT_TDATA_W - 10){1'b0}}, old_dirty, res_hit, res_data};
        end
      end
      default: begin
      end
    endcase
  end

  dmwbc_ram #(.WIDTH(TAG_W + 1), .DEPTH(LINE_COUNT)) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  dmwbc_ram #(.WIDTH(8), .DEPTH(LINE_COUNT * LINE_BYTES)) u_lines (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  dmwbc_ram #(.WIDTH(8), .DEPTH(2 ** ADDR_BITS)) u_backing (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .raddr (back_raddr),
    .rdata (back_rdata)
  );

endmodule
`default_nettype wire

### tb/direct_mapped_write_back_cache_tb.sv
// Testbench for the direct-mapped write-back cache: directed and random byte traffic.
`timescale 1ns / 100ps
module direct_mapped_write_back_cache_tb;
  import dmwbc_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hit;
    logic       dirty;
  } read_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // address[15:0], write_data[23:16]
  logic                   s_tuser = 1'b0; // req_type
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // read_data[7:0], hit[8], dirty[9]

  // Shadow copy of the cache and its backing memory.
  logic [7:0] cache_bytes [0:255];
  logic [7:0] cache_tags  [0:31];
  logic       cache_dirty [0:31];
  logic [7:0] backing_mem [0:65535];

  read_result_t pending_reads[$];
  int  fail_count = 0;
  bit  steady = 1'b0;   // no idling on either side while set

  direct_mapped_write_back_cache uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < 65536; i++) backing_mem[i] = 8'h00;
    for (int i = 0; i < 256; i++) cache_bytes[i] = 8'h00;
    for (int i = 0; i < 32; i++) begin
      cache_tags[i]  = 8'h00;
      cache_dirty[i] = 1'b0;
    end
  endfunction

  // Applies one accepted request to the shadow state; reads queue their result.
  function automatic void cache_access(input logic kind, input logic [15:0] addr,
                                       input logic [7:0] wdata);
    logic [4:0]   line;
    logic [7:0]   tag;
    logic [2:0]   off;
    logic         was_hit;
    logic         was_dirty;
    logic [3:0]   i;
    read_result_t r;
    line      = addr[7:3];
    tag       = addr[15:8];
    off       = addr[2:0];
    was_hit   = (cache_tags[line] == tag);
    was_dirty = cache_dirty[line];
    if (!was_hit) begin
      if (was_dirty)
        for (i = 0; i < 8; i++)
          backing_mem[{cache_tags[line], line, i[2:0]}] = cache_bytes[{line, i[2:0]}];
      for (i = 0; i < 8; i++)
        cache_bytes[{line, i[2:0]}] = backing_mem[{tag, line, i[2:0]}];
      cache_tags[line] = tag;
      if (kind == REQ_READ) cache_dirty[line] = 1'b0;
    end
    if (kind == REQ_WRITE) begin
      cache_bytes[{line, off}] = wdata;
      cache_dirty[line] = 1'b1;
    end else begin
      r.read_data = cache_bytes[{line, off}];
      r.hit       = was_hit;
      r.dirty     = was_dirty;
      pending_reads = {pending_reads, r};
    end
  endfunction

  // Drives one request beat and waits for it to be taken.
  task automatic send_req(input logic kind, input logic [15:0] addr, input logic [7:0] wdata);
    if (!steady)
      while ($urandom_range(0, 99) < 29) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {wdata, addr};
    do @(posedge clk); while (!s_tready);
    cache_access(kind, addr, wdata);
  endtask

  // Result checker and sink-side idling.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected read beat: m_tdata=%h", m_tdata);
        fail_count++;
      end else begin
        read_result_t want;
        want = pending_reads.pop_front();
        if (m_tdata[7:0] !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[8] !== want.hit) begin
          $error("hit: expected %b, actual %b", want.hit, m_tdata[8]);
          fail_count++;
        end
        if (m_tdata[9] !== want.dirty) begin
          $error("dirty: expected %b, actual %b", want.dirty, m_tdata[9]);
          fail_count++;
        end
      end
    end
    m_tready <= steady || ($urandom_range(0, 99) >= 29);
  end

  // After reset every line holds tag 0, so tag-0 reads hit and return zero.
  task automatic test_reset_state();
    send_req(REQ_READ, 16'h0000, 8'h00);
    send_req(REQ_READ, 16'h00FF, 8'hFF);
  endtask

  task automatic test_field_extremes();
    send_req(REQ_WRITE, 16'h00FF, 8'hFF);
    send_req(REQ_READ,  16'h00FF, 8'h00);
    send_req(REQ_READ,  16'hFFFF, 8'hFF);   // evicts dirty tag-0 line
    send_req(REQ_WRITE, 16'hFFF8, 8'hA5);
    send_req(REQ_READ,  16'h00F8, 8'h00);
    send_req(REQ_READ,  16'hFFF8, 8'h00);   // written-back byte comes back
    send_req(REQ_READ,  16'h00FF, 8'h00);
  endtask

  task automatic test_clean_miss();
    send_req(REQ_READ, 16'h1234, 8'h00);
    send_req(REQ_READ, 16'h1235, 8'h00);
  endtask

  task automatic test_write_miss();
    send_req(REQ_WRITE, 16'h2010, 8'h5A);
    send_req(REQ_READ,  16'h2010, 8'h00);
    send_req(REQ_READ,  16'h0010, 8'h00);
    send_req(REQ_READ,  16'h2017, 8'h00);
  endtask

  task automatic test_dirty_miss();
    send_req(REQ_WRITE, 16'h3308, 8'h11);
    send_req(REQ_WRITE, 16'h330F, 8'h22);
    send_req(REQ_READ,  16'h4408, 8'h00);
    send_req(REQ_READ,  16'h330F, 8'h00);
    send_req(REQ_READ,  16'h3308, 8'h00);
  endtask

  // Mostly a few hot tags so lines conflict, get dirty and come back; some fully random.
  task automatic test_random_traffic();
    logic [7:0]  hot_tags [0:3];
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    hot_tags[0] = 8'h00;
    for (int i = 1; i < 4; i++) hot_tags[i] = 8'($urandom_range(0, 255));
    for (int n = 0; n < 600; n++) begin
      steady = (n >= 250 && n < 400);
      kind   = 1'($urandom_range(0, 1));
      wdata  = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 80)
        addr = {hot_tags[$urandom_range(0, 3)], 5'($urandom_range(0, 31)),
                3'($urandom_range(0, 7))};
      else
        addr = 16'($urandom_range(0, 65535));
      send_req(kind, addr, wdata);
    end
    steady = 1'b0;
  endtask

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_field_extremes();
    test_clean_miss();
    test_write_miss();
    test_dirty_miss();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Covers the clearing pass after reset plus the traffic, several times over.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/dmwbc_pkg.sv
hdl/dmwbc_ram.sv
hdl/direct_mapped_write_back_cache.sv
tb/direct_mapped_write_back_cache_tb.sv
